// ----- src/arsb_pkg.sv -----
package arsb_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int NUM_READINGS = 4;
	localparam int GAIN_W       = 2;
	localparam int LEN_W        = 4;
	localparam int BNUM_W       = 16;

	localparam logic [SAMPLE_W-1:0] RESET_LIMIT = 16'd64000;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [GAIN_W-1:0]   gain_t;
	typedef logic [BNUM_W-1:0]   bnum_t;

	// one stored batch entry: chosen reading and the gain it was taken at
	typedef struct packed {
		sample_t value;
		gain_t   gain;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

// ----- src/autorange_sample_batcher_top.sv -----
// Auto-ranging sample batcher.
// Input channel (in_valid / in_stall): one measurement per transfer, four
// readings at increasing gain plus end_of_run. The highest gain whose reading
// is at or below range_limit is kept (gain 0 if none), and the entry is written
// into a BATCH_SIZE-deep synchronous store at the current fill position.
// A measurement that does not close a batch is taken without a stall.
// When the store fills, or on end_of_run, the batch drains on the output
// channel (out_valid / out_stall), one transfer per entry, in store order.
// Each entry takes a read on the single read port; the registered read
// data moves into the output register the cycle after, and no new read
// issues while one is pending. in_stall stays high while a batch is read
// out; the last entry may still wait in the output register while the
// next input is taken. When the receiver stalls, the output register holds
// and no further reads are issued. Reset clears the fill count, the batch
// number and the output valid flag, and loads range_limit with 64000; the
// store itself is not cleared, since only written entries are ever read.
// range_limit is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
module autorange_sample_batcher_top import arsb_pkg::*; #(
	parameter int BATCH_SIZE = 10,
	parameter int GAIN_STEPS = 4
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_wr_en,
	input  logic [SAMPLE_W-1:0] cfg_wr_data,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample_step0,
	input  logic [SAMPLE_W-1:0] sample_step1,
	input  logic [SAMPLE_W-1:0] sample_step2,
	input  logic [SAMPLE_W-1:0] sample_step3,
	input  logic                end_of_run,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [BNUM_W-1:0]   batch_number,
	output logic [LEN_W-1:0]    batch_length,
	output logic [LEN_W-1:0]    entry_index,
	output logic [SAMPLE_W-1:0] sample_value,
	output logic [GAIN_W-1:0]   gain_step,
	output logic                last_of_batch
);

	localparam int CNT_W  = $clog2(BATCH_SIZE + 1);
	localparam int ADDR_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

	state_t state_q, state_nxt;

	sample_t          range_limit_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] rd_ptr_q;
	bnum_t            batch_cnt_q;
	bnum_t            bnum_q;

	entry_t mem [BATCH_SIZE];

	entry_t           rdata_s1;
	logic             rd_pend_s1;
	logic [CNT_W-1:0] idx_s1;
	logic [CNT_W-1:0] len_s1;
	bnum_t            bnum_s1;
	logic             last_s1;

	logic             out_valid_q;
	bnum_t            out_bnum_q;
	logic [LEN_W-1:0] out_len_q;
	logic [LEN_W-1:0] out_idx_q;
	entry_t           out_entry_q;
	logic             out_last_q;

	sample_t [NUM_READINGS-1:0] readings;
	entry_t                     sel_entry;
	logic                       in_xfer;
	logic [CNT_W-1:0]           new_fill;
	logic                       flush;
	logic                       rd_issue;
	logic                       rd_final;

	assign readings = {sample_step3, sample_step2, sample_step1, sample_step0};

	arsb_gain_sel #(
		.GAIN_STEPS(GAIN_STEPS)
	) u_gain_sel (
		.readings(readings),
		.limit   (range_limit_q),
		.sel     (sel_entry)
	);

	assign in_xfer  = in_valid && !in_stall;
	assign new_fill = fill_q + CNT_W'(1);
	assign flush    = (new_fill == CNT_W'(BATCH_SIZE)) || end_of_run;
	assign rd_final = (rd_ptr_q == len_q - CNT_W'(1));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && flush) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (rd_issue && rd_final) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs: issue a read only when the output register is free by
	// the time the data lands
	always_comb begin
		in_stall = 1'b1;
		rd_issue = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_DRAIN: begin
				rd_issue = !rd_pend_s1 && (!out_valid_q || !out_stall);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			range_limit_q <= RESET_LIMIT;
			fill_q        <= '0;
			len_q         <= '0;
			rd_ptr_q      <= '0;
			batch_cnt_q   <= '0;
			bnum_q        <= '0;
			rd_pend_s1    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			rd_pend_s1 <= rd_issue;
			if (cfg_wr_en) begin
				range_limit_q <= cfg_wr_data;
			end
			if (in_xfer) begin
				if (flush) begin
					fill_q      <= '0;
					len_q       <= new_fill;
					rd_ptr_q    <= '0;
					bnum_q      <= batch_cnt_q;
					batch_cnt_q <= end_of_run ? '0 : batch_cnt_q + BNUM_W'(1);
				end else begin
					fill_q <= new_fill;
				end
			end else if (rd_issue) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
			if (rd_pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// batch store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mem[fill_q[ADDR_W-1:0]] <= sel_entry;
		end
		if (rd_issue) begin
			rdata_s1 <= mem[rd_ptr_q[ADDR_W-1:0]];
			idx_s1   <= rd_ptr_q;
			len_s1   <= len_q;
			bnum_s1  <= bnum_q;
			last_s1  <= rd_final;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_bnum_q  <= bnum_s1;
			out_len_q   <= LEN_W'(len_s1);
			out_idx_q   <= LEN_W'(idx_s1);
			out_entry_q <= rdata_s1;
			out_last_q  <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign batch_number  = out_bnum_q;
	assign batch_length  = out_len_q;
	assign entry_index   = out_idx_q;
	assign sample_value  = out_entry_q.value;
	assign gain_step     = out_entry_q.gain;
	assign last_of_batch = out_last_q;

	// read data must never land on a full output register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !out_valid_q)
		else $error("read data arrived while output register was occupied");

	// the fill count stays below the batch size between measurements
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(BATCH_SIZE))
		else $error("fill count reached batch size outside a flush");

	// a closing measurement starts a drain with an empty fill count
	a_flush_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && flush) |=> (state_q == ST_DRAIN) && (fill_q == '0) && (rd_ptr_q == '0))
		else $error("flush did not start a drain from entry zero");

	// reads stay within the batch being drained
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (rd_ptr_q < len_q))
		else $error("read issued past the batch length");

	// a drain never lets a new measurement in before its last read issues
	a_drain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && !(rd_issue && rd_final)) |=> (state_q == ST_DRAIN))
		else $error("drain ended before the last entry was read");

endmodule

// ----- src/arsb_gain_sel.sv -----
module arsb_gain_sel import arsb_pkg::*; #(
	parameter int GAIN_STEPS = 4
) (
	input  sample_t [NUM_READINGS-1:0] readings,
	input  sample_t                    limit,
	output entry_t                     sel
);

	localparam int SEARCH = (GAIN_STEPS < NUM_READINGS) ? GAIN_STEPS : NUM_READINGS;

	gain_t gain;

	// later (higher) gains override, so the highest in-range gain wins;
	// gain 0 is the fallback when nothing is in range
	always_comb begin
		gain = '0;
		for (int g = 0; g < SEARCH; g++) begin
			if (readings[g] <= limit) begin
				gain = GAIN_W'(g);
			end
		end
	end

	assign sel.gain  = gain;
	assign sel.value = readings[gain];

endmodule

// ----- sim/autorange_sample_batcher_top_tb.sv -----
`timescale 1ns / 1ps

module autorange_sample_batcher_top_tb;
	import arsb_pkg::*;

	localparam int BATCH_SIZE   = 10;
	localparam int GAIN_STEPS   = 4;
	localparam int CLK_PERIOD   = 12;
	localparam int SETTLE_TICKS = 4;

	typedef struct {
		bnum_t            bnum;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] idx;
		sample_t          value;
		gain_t            gain;
		logic             last;
	} drained_entry_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_wr_en    = 1'b0;
	sample_t          cfg_wr_data  = '0;
	logic             in_valid     = 1'b0;
	logic             in_stall;
	sample_t          sample_step0 = '0;
	sample_t          sample_step1 = '0;
	sample_t          sample_step2 = '0;
	sample_t          sample_step3 = '0;
	logic             end_of_run   = 1'b0;
	logic             out_valid;
	logic             out_stall    = 1'b0;
	bnum_t            batch_number;
	logic [LEN_W-1:0] batch_length;
	logic [LEN_W-1:0] entry_index;
	sample_t          sample_value;
	gain_t            gain_step;
	logic             last_of_batch;

	// shadow of the block: store, fill position, batch number, limit
	entry_t         stored_entries [BATCH_SIZE];
	int unsigned    fill_model;
	bnum_t          batch_model;
	sample_t        limit_model;
	drained_entry_t pending_entries [$];

	sample_t     cur_limit      = RESET_LIMIT;
	int unsigned idle_pct       = 30;
	int unsigned mismatch_count = 0;

	autorange_sample_batcher_top #(
		.BATCH_SIZE(BATCH_SIZE),
		.GAIN_STEPS(GAIN_STEPS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_step0 (sample_step0),
		.sample_step1 (sample_step1),
		.sample_step2 (sample_step2),
		.sample_step3 (sample_step3),
		.end_of_run   (end_of_run),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.batch_number (batch_number),
		.batch_length (batch_length),
		.entry_index  (entry_index),
		.sample_value (sample_value),
		.gain_step    (gain_step),
		.last_of_batch(last_of_batch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	function automatic void select_and_batch(input sample_t r0, input sample_t r1,
			input sample_t r2, input sample_t r3, input logic eor);
		sample_t        rd [NUM_READINGS];
		gain_t          g;
		logic           found;
		int             k;
		drained_entry_t e;
		rd = '{r0, r1, r2, r3};
		g = '0;
		found = 1'b0;
		// highest gain in range wins; fall back to gain 0
		for (k = ((GAIN_STEPS < NUM_READINGS) ? GAIN_STEPS : NUM_READINGS) - 1; k >= 0; k--) begin
			if (!found && rd[k] <= limit_model) begin
				g = gain_t'(k);
				found = 1'b1;
			end
		end
		stored_entries[fill_model].value = rd[g];
		stored_entries[fill_model].gain  = g;
		fill_model++;
		if (fill_model == BATCH_SIZE || eor) begin
			for (k = 0; k < fill_model; k++) begin
				e.bnum  = batch_model;
				e.len   = LEN_W'(fill_model);
				e.idx   = LEN_W'(k);
				e.value = stored_entries[k].value;
				e.gain  = stored_entries[k].gain;
				e.last  = (k + 1 == fill_model);
				pending_entries.push_back(e);
			end
			fill_model = 0;
			batch_model++;
			if (eor)
				batch_model = '0;
		end
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		drained_entry_t e;
		if (!arst_n) begin
			fill_model  = 0;
			batch_model = '0;
			limit_model = RESET_LIMIT;
		end else begin
			if (cfg_wr_en)
				limit_model = cfg_wr_data;
			if (in_valid && !in_stall)
				select_and_batch(sample_step0, sample_step1, sample_step2, sample_step3,
					end_of_run);
			if (out_valid && !out_stall) begin
				if (pending_entries.size() == 0) begin
					$display("%0t: unexpected transfer: expected none, actual sample %0d gain %0d",
						$time, sample_value, gain_step);
					mismatch_count++;
				end else begin
					e = pending_entries.pop_front();
					check_field("batch_number", 32'(e.bnum), 32'(batch_number));
					check_field("batch_length", 32'(e.len), 32'(batch_length));
					check_field("entry_index", 32'(e.idx), 32'(entry_index));
					check_field("sample_value", 32'(e.value), 32'(sample_value));
					check_field("gain_step", 32'(e.gain), 32'(gain_step));
					check_field("last_of_batch", 32'(e.last), 32'(last_of_batch));
				end
			end
		end
	end

	task automatic send_measurement(input sample_t r0, input sample_t r1, input sample_t r2,
			input sample_t r3, input logic eor);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_step0 <= r0;
		sample_step1 <= r1;
		sample_step2 <= r2;
		sample_step3 <= r3;
		end_of_run   <= eor;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic sample_t rand_reading();
		// cluster around the limit so every gain gets picked
		case ($urandom_range(5))
			0: return sample_t'($urandom);
			1: return cur_limit;
			2: return sample_t'(cur_limit + 1);
			3: return sample_t'($urandom_range(cur_limit));
			4: return (cur_limit == '1) ? sample_t'($urandom)
				: sample_t'($urandom_range(16'hFFFF, cur_limit + 1));
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	task automatic send_random(input logic eor);
		send_measurement(rand_reading(), rand_reading(), rand_reading(), rand_reading(), eor);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_entries.size() != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_range_limit(input sample_t limit);
		wait_for_drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= limit;
		cur_limit = limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_gain_selection();
		send_measurement(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		send_measurement(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_measurement(16'd100, 16'd200, 16'd300, 16'd64000, 1'b0);
		send_measurement(16'd100, 16'd200, 16'd64000, 16'd64001, 1'b0);
		send_measurement(16'd100, 16'd64000, 16'd64001, 16'hFFFF, 1'b0);
		send_measurement(16'd64000, 16'd64001, 16'hFFFF, 16'hFFFF, 1'b0);
		send_measurement(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
	endtask

	task automatic test_batch_boundaries();
		int k;
		for (k = 0; k < BATCH_SIZE; k++)
			send_random(1'b0);
		// full batch closed by the final measurement
		for (k = 0; k < BATCH_SIZE; k++)
			send_random(k == BATCH_SIZE - 1);
		send_random(1'b1);
	endtask

	task automatic test_range_limit_extremes();
		write_range_limit(16'd0);
		send_measurement(16'd0, 16'd1, 16'd0, 16'd1, 1'b0);
		send_measurement(16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
		send_measurement(16'd1, 16'd0, 16'd1, 16'd1, 1'b1);
		write_range_limit(16'hFFFF);
		send_measurement(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_random(1'b0);
		send_random(1'b1);
		write_range_limit(sample_t'($urandom));
	endtask

	task automatic test_random_runs(input int unsigned n_items);
		int unsigned sent;
		int unsigned run_len;
		int unsigned pick;
		int unsigned k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(3))
					0: write_range_limit(16'd0);
					1: write_range_limit(16'hFFFF);
					default: write_range_limit(sample_t'($urandom));
				endcase
			end
			pick = $urandom_range(99);
			if (pick < 55)
				run_len = $urandom_range(BATCH_SIZE - 1, 1);
			else if (pick < 80)
				run_len = BATCH_SIZE;
			else
				run_len = $urandom_range(25, BATCH_SIZE + 1);
			for (k = 1; k <= run_len; k++)
				send_random(k == run_len);
			sent += run_len;
		end
	endtask

	task automatic test_streaming_no_gaps();
		int unsigned run_len;
		int unsigned r;
		int unsigned k;
		idle_pct = 0;
		for (r = 0; r < 3; r++) begin
			run_len = $urandom_range(15, 8);
			for (k = 1; k <= run_len; k++)
				send_random(k == run_len);
		end
		idle_pct = 30;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_gain_selection();
		test_batch_boundaries();
		test_range_limit_extremes();
		test_random_runs(35);
		test_streaming_no_gaps();
		wait_for_drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d transfers still outstanding", $time,
			pending_entries.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
